/* hdl/mbrot_pkg.sv */
package mbrot_pkg;

    localparam int unsigned CFG_W       = 32;
    localparam int unsigned ITER_W      = 16;
    localparam int unsigned OUT_COORD_W = 11;
    localparam int unsigned RGB_W       = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned PROD_W      = 64;
    localparam int unsigned WIDE_W      = 66;
    localparam int unsigned MOD_IN_W    = 19;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd4;

    // reset values: -2.0, -1.2 and the default steps in Q4.28
    localparam logic signed [CFG_W-1:0] RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic signed [CFG_W-1:0] RST_IMAG_ORIGIN = -32'sd322122547;
    localparam logic signed [CFG_W-1:0] RST_REAL_STEP   = 32'sd1260260;
    localparam logic signed [CFG_W-1:0] RST_IMAG_STEP   = 32'sd1260918;
    localparam logic [ITER_W-1:0]       RST_MAX_ITER    = 16'd100;

    localparam logic [RGB_W-1:0] MOD_BASE = 8'd255;

    typedef struct packed {
        logic signed [CFG_W-1:0] real_origin;
        logic signed [CFG_W-1:0] imag_origin;
        logic signed [CFG_W-1:0] real_step;
        logic signed [CFG_W-1:0] imag_step;
        logic [ITER_W-1:0]       max_iter;
    } t_cfg;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] col;
        logic [OUT_COORD_W-1:0] row;
        logic [ITER_W-1:0]      count;
        logic                   in_set;
    } t_res;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [CFG_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-CFG_W:0] top;
        top = v[WIDE_W-1:CFG_W-1];
        if (top == '0 || top == '1) begin
            return v[CFG_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // v mod 255 by folding bytes, then one compare and subtract
    function automatic logic [RGB_W-1:0] f_mod255(input logic [MOD_IN_W-1:0] v);
        logic [9:0] s1;
        logic [8:0] s2;
        s1 = {2'b00, v[7:0]} + {2'b00, v[15:8]} + {7'b0, v[18:16]};
        s2 = {1'b0, s1[7:0]} + {7'b0, s1[9:8]};
        if (s2 >= {1'b0, MOD_BASE}) begin
            s2 = s2 - {1'b0, MOD_BASE};
        end
        return s2[RGB_W-1:0];
    endfunction

endpackage

/* hdl/mbrot_cfg.sv */
module mbrot_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [mbrot_pkg::CFG_W-1:0]         i_data,
    output mbrot_pkg::t_cfg                     o_cfg
);

    mbrot_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin <= mbrot_pkg::RST_REAL_ORIGIN;
            r_cfg.imag_origin <= mbrot_pkg::RST_IMAG_ORIGIN;
            r_cfg.real_step   <= mbrot_pkg::RST_REAL_STEP;
            r_cfg.imag_step   <= mbrot_pkg::RST_IMAG_STEP;
            r_cfg.max_iter    <= mbrot_pkg::RST_MAX_ITER;
        end else if (i_we) begin
            case (i_index)
                mbrot_pkg::CFG_REAL_ORIGIN: r_cfg.real_origin <= $signed(i_data);
                mbrot_pkg::CFG_IMAG_ORIGIN: r_cfg.imag_origin <= $signed(i_data);
                mbrot_pkg::CFG_REAL_STEP:   r_cfg.real_step   <= $signed(i_data);
                mbrot_pkg::CFG_IMAG_STEP:   r_cfg.imag_step   <= $signed(i_data);
                mbrot_pkg::CFG_MAX_ITER:    r_cfg.max_iter    <= i_data[mbrot_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/mbrot_mul.sv */
module mbrot_mul (
    input  logic                                i_clk,
    input  logic signed [mbrot_pkg::CFG_W-1:0]  i_a,
    input  logic signed [mbrot_pkg::CFG_W-1:0]  i_b,
    output logic signed [mbrot_pkg::PROD_W-1:0] o_p
);

    logic signed [mbrot_pkg::PROD_W-1:0] r_p;

    // one signed 32x32 product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* hdl/mbrot_seq.sv */
module mbrot_seq #(
    parameter int unsigned FRAC_BITS  = 28,
    parameter int unsigned COORD_BITS = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbrot_pkg::t_cfg         i_cfg,
    input  logic                    i_start,
    input  logic [COORD_BITS-1:0]   i_col,
    input  logic [COORD_BITS-1:0]   i_row,
    input  logic                    i_free,
    output logic                    o_busy,
    output logic                    o_done,
    output mbrot_pkg::t_res         o_res
);

    localparam int unsigned CW = mbrot_pkg::CFG_W;
    localparam int unsigned PW = mbrot_pkg::PROD_W;
    localparam int unsigned WW = mbrot_pkg::WIDE_W;
    localparam int unsigned NW = mbrot_pkg::ITER_W;
    localparam int unsigned OW = mbrot_pkg::OUT_COORD_W;
    localparam logic [PW-1:0] LIMIT = 64'd4 << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MAP_RE, S_MAP_IM, S_MAP_END, S_SQX, S_SQY, S_XY, S_UPD
    } t_state;
    localparam t_state S_DONE_ST = S_IDLE;

    // result held here until the output register takes it
    logic r_done, n_done;

    t_state                r_state, n_state;
    logic [COORD_BITS-1:0] r_col, n_col, r_row, n_row;
    logic signed [CW-1:0]  r_x, n_x, r_y, n_y, r_c_re, n_c_re, r_c_im, n_c_im;
    logic signed [PW-1:0]  r_xx, n_xx, r_yy, n_yy;
    logic [NW-1:0]         r_n, n_n, r_count, n_count;
    logic                  r_inside, n_inside;

    logic signed [CW-1:0]  w_mul_a, w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_diff, w_re_sh, w_im_sh;
    logic signed [WW-1:0]  w_map_sum, w_re_sum, w_im_sum;
    logic signed [CW-1:0]  w_map_org;
    logic [PW-1:0]         w_mag;
    logic                  w_esc;
    logic [NW:0]           w_n_inc;
    logic [OW+COORD_BITS-1:0] w_col_ext, w_row_ext;

    mbrot_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_MAP_RE: begin
                w_mul_a = $signed({{(CW-COORD_BITS){1'b0}}, r_col});
                w_mul_b = i_cfg.real_step;
            end
            S_MAP_IM: begin
                w_mul_a = $signed({{(CW-COORD_BITS){1'b0}}, r_row});
                w_mul_b = i_cfg.imag_step;
            end
            S_SQX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            S_SQY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
        endcase
    end

    always_comb begin
        w_map_org = (r_state == S_MAP_IM) ? i_cfg.real_origin : i_cfg.imag_origin;
        w_map_sum = $signed({{(WW-PW){w_prod[PW-1]}}, w_prod})
                  + $signed({{(WW-CW){w_map_org[CW-1]}}, w_map_org});
        w_diff    = r_xx - r_yy;
        w_re_sh   = w_diff >>> FRAC_BITS;
        w_im_sh   = w_prod >>> (FRAC_BITS - 1);
        w_re_sum  = $signed({{(WW-PW){w_re_sh[PW-1]}}, w_re_sh})
                  + $signed({{(WW-CW){r_c_re[CW-1]}}, r_c_re});
        w_im_sum  = $signed({{(WW-PW){w_im_sh[PW-1]}}, w_im_sh})
                  + $signed({{(WW-CW){r_c_im[CW-1]}}, r_c_im});
        w_mag     = ($unsigned(r_xx) >> FRAC_BITS) + ($unsigned(r_yy) >> FRAC_BITS);
        w_esc     = w_mag > LIMIT;
        w_n_inc   = {1'b0, r_n} + {{NW{1'b0}}, 1'b1};
    end

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_col    = r_col;
        n_row    = r_row;
        n_x      = r_x;
        n_y      = r_y;
        n_c_re   = r_c_re;
        n_c_im   = r_c_im;
        n_xx     = r_xx;
        n_yy     = r_yy;
        n_n      = r_n;
        n_count  = r_count;
        n_inside = r_inside;

        if (r_done) begin
            if (i_free) begin
                n_done  = 1'b0;
                n_state = S_DONE_ST;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        n_col   = i_col;
                        n_row   = i_row;
                        n_state = S_MAP_RE;
                    end
                end
                S_MAP_RE: begin
                    n_state = S_MAP_IM;
                end
                S_MAP_IM: begin
                    n_c_re  = mbrot_pkg::f_sat32(w_map_sum);
                    n_x     = n_c_re;
                    n_state = S_MAP_END;
                end
                S_MAP_END: begin
                    n_c_im = mbrot_pkg::f_sat32(w_map_sum);
                    n_y    = n_c_im;
                    n_n    = '0;
                    if (i_cfg.max_iter == '0) begin
                        // zero limit: no step is run
                        n_count  = '0;
                        n_inside = 1'b1;
                        n_done   = 1'b1;
                        n_state  = S_UPD;
                    end else begin
                        n_state = S_SQX;
                    end
                end
                S_SQX: begin
                    n_state = S_SQY;
                end
                S_SQY: begin
                    n_xx    = w_prod;
                    n_state = S_XY;
                end
                S_XY: begin
                    n_yy    = w_prod;
                    n_state = S_UPD;
                end
                S_UPD: begin
                    if (w_esc) begin
                        n_count  = r_n;
                        n_inside = 1'b0;
                        n_done   = 1'b1;
                    end else begin
                        n_x = mbrot_pkg::f_sat32(w_re_sum);
                        n_y = mbrot_pkg::f_sat32(w_im_sum);
                        n_n = w_n_inc[NW-1:0];
                        if (w_n_inc == {1'b0, i_cfg.max_iter}) begin
                            n_count  = i_cfg.max_iter;
                            n_inside = 1'b1;
                            n_done   = 1'b1;
                        end else begin
                            n_state = S_SQX;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_row    <= n_row;
        r_x      <= n_x;
        r_y      <= n_y;
        r_c_re   <= n_c_re;
        r_c_im   <= n_c_im;
        r_xx     <= n_xx;
        r_yy     <= n_yy;
        r_n      <= n_n;
        r_count  <= n_count;
        r_inside <= n_inside;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        w_col_ext = {{OW{1'b0}}, r_col};
        w_row_ext = {{OW{1'b0}}, r_row};
    end

    assign o_busy       = r_done || (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_res.col    = w_col_ext[OW-1:0];
    assign o_res.row    = w_row_ext[OW-1:0];
    assign o_res.count  = r_count;
    assign o_res.in_set = r_inside;

endmodule

/* hdl/mbrot_colour.sv */
module mbrot_colour (
    input  logic [mbrot_pkg::ITER_W-1:0]    i_count,
    input  logic                            i_inside,
    input  logic [mbrot_pkg::ITER_W-1:0]    i_max_iter,
    output logic [mbrot_pkg::RGB_W-1:0]     o_red,
    output logic [mbrot_pkg::RGB_W-1:0]     o_green,
    output logic [mbrot_pkg::RGB_W-1:0]     o_blue
);

    localparam int unsigned MW = mbrot_pkg::MOD_IN_W;
    localparam int unsigned NW = mbrot_pkg::ITER_W;

    logic [MW-1:0]                  w_count_ext, w_five;
    logic [NW-1:0]                  w_half;
    logic [mbrot_pkg::RGB_W-1:0]    w_red_band, w_grey;

    always_comb begin
        w_count_ext = {{(MW-NW){1'b0}}, i_count};
        w_five      = (w_count_ext << 2) + w_count_ext;
        w_half      = i_max_iter >> 1;
        w_red_band  = mbrot_pkg::f_mod255(w_five);
        w_grey      = mbrot_pkg::f_mod255(w_count_ext);
        o_red   = '0;
        o_green = '0;
        o_blue  = '0;
        if (!i_inside) begin
            if (i_count < w_half) begin
                // early escape, red band
                o_red = w_red_band;
            end else begin
                o_red   = w_grey;
                o_green = w_grey;
                o_blue  = w_grey;
            end
        end
    end

endmodule

/* hdl/mandelbrot_escape_time_pixel_unit.sv */
// each accepted pixel is mapped and then run through k iteration steps (n+1 for an escape
//   at step n, max_iter when inside, 0 for a zero limit); a new pixel waits for the last one
// each step runs S_SQX, S_SQY, S_XY and S_UPD: x*x, y*y and x*y through the one shared
//   32x32 multiplier, then the escape test and update
// reset: synchronous, active low; config registers return to their defaults, the sequencer
//   goes idle and the output word is dropped
module mandelbrot_escape_time_pixel_unit #(
    parameter int unsigned FRAC_BITS  = 28,
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mbrot_pkg::CFG_W-1:0]             i_cfg_data,
    // pixel input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [COORD_BITS-1:0]                   i_col,
    input  logic [COORD_BITS-1:0]                   i_row,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [mbrot_pkg::OUT_COORD_W-1:0]       o_out_col,
    output logic [mbrot_pkg::OUT_COORD_W-1:0]       o_out_row,
    output logic [mbrot_pkg::RGB_W-1:0]             o_red,
    output logic [mbrot_pkg::RGB_W-1:0]             o_green,
    output logic [mbrot_pkg::RGB_W-1:0]             o_blue,
    output logic                                    o_inside_res,
    output logic [mbrot_pkg::ITER_W-1:0]            o_escape_count
);

    // escape count is reported modulo 2^COUNT_BITS
    localparam logic [mbrot_pkg::ITER_W-1:0] CNT_MASK =
        (COUNT_BITS >= mbrot_pkg::ITER_W) ? '1 :
        mbrot_pkg::ITER_W'((32'd1 << COUNT_BITS) - 32'd1);

    mbrot_pkg::t_cfg    w_cfg;
    mbrot_pkg::t_res    w_res;
    logic               w_busy;
    logic               w_done;
    logic               w_free;
    logic               w_load;
    logic [mbrot_pkg::RGB_W-1:0] w_red, w_green, w_blue;

    // output register, the only buffer between the sequencer and the sink
    logic                                   r_out_valid;
    logic [mbrot_pkg::OUT_COORD_W-1:0]      r_out_col, r_out_row;
    logic [mbrot_pkg::RGB_W-1:0]            r_red, r_green, r_blue;
    logic                                   r_inside;
    logic [mbrot_pkg::ITER_W-1:0]           r_count;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    mbrot_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // one pixel at a time: the sequencer holds off new words until its result is handed on
    mbrot_seq #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_start (i_in_valid && !o_in_stall),
        .i_col   (i_col),
        .i_row   (i_row),
        .i_free  (w_free),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // colour lookup sits in front of the output register
    mbrot_colour u_colour (
        .i_count    (w_res.count),
        .i_inside   (w_res.in_set),
        .i_max_iter (w_cfg.max_iter),
        .o_red      (w_red),
        .o_green    (w_green),
        .o_blue     (w_blue)
    );

    assign o_in_stall = w_busy;

    // output slot is free when empty or being taken this cycle
    assign w_free = !r_out_valid || !i_out_stall;
    assign w_load = w_done && w_free;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_col <= w_res.col;
            r_out_row <= w_res.row;
            r_red     <= w_red;
            r_green   <= w_green;
            r_blue    <= w_blue;
            r_inside  <= w_res.in_set;
            r_count   <= w_res.count & CNT_MASK;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_inside_res   = r_inside;
    assign o_escape_count = r_count;

endmodule

/* hdl/mbrot_chk.sv */
module mbrot_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [10:0] o_out_col,
    input  logic [10:0] o_out_row,
    input  logic [7:0]  o_red,
    input  logic [7:0]  o_green,
    input  logic [7:0]  o_blue,
    input  logic        o_inside_res,
    input  logic [15:0] o_escape_count
);

    // a word held under stall keeps its valid, coordinates, red, escape count and inside flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_col)
        && $stable(o_out_row) && $stable(o_red) && $stable(o_escape_count)
        && $stable(o_inside_res))
        else $error("stalled output word changed");

    // an accepted pixel makes the block busy, so the input is not taken again straight after
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // inside points are painted black
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_res |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
        else $error("inside pixel not black");

    // colour is either pure red or grey
    a_red_or_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_green == o_blue && (o_green == 8'd0 || o_red == o_green))
        else $error("colour outside the red and grey bands");

endmodule

bind mandelbrot_escape_time_pixel_unit mbrot_chk u_mbrot_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_col      (o_out_col),
    .o_out_row      (o_out_row),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue),
    .o_inside_res   (o_inside_res),
    .o_escape_count (o_escape_count)
);
